// ===== design/ray_box_slab_intersection_assert.svh =====
// Assertion macros shared by the slab test RTL.
// Each macro expects a clock named clk and a synchronous reset named rst.
`ifndef RAY_BOX_SLAB_INTERSECTION_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECTION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBSI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RBSI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rbsi_pkg.sv =====
`timescale 1ns / 1ps
package rbsi_pkg;

  // Datapath widths, fixed by the Q formats of the fields.
  localparam int PROD_W = 32;        // 16 x 16 signed product
  localparam int SUM_W  = 34;        // transformed origin or direction
  localparam int NUM_W  = 35;        // bound minus origin, 20 fraction bits
  localparam int MAG_W  = 34;        // magnitude of that difference
  localparam int FRAC_SHIFT = 22;    // scale that lands the quotient at Q16.16
  localparam int DVD_W  = MAG_W + FRAC_SHIFT;  // dividend and quotient width
  localparam int REM_W  = 33;        // divisor and remainder width
  localparam int T_W    = 58;        // signed slab distance with headroom
  localparam int PAR_EPS = 67;       // parallel threshold at 26 fraction bits

  typedef enum logic [2:0] {
    CFG_ROW_X    = 3'd0,
    CFG_ROW_Y    = 3'd1,
    CFG_ROW_Z    = 3'd2,
    CFG_BOX_LOW  = 3'd3,
    CFG_BOX_HIGH = 3'd4
  } cfg_index_t;

  // Per-ray flags that ride along with the divider lanes.
  typedef struct packed {
    logic [2:0] par;       // axis is parallel to its slab
    logic       par_miss;  // origin outside a parallel slab
    logic [5:0] neg;       // quotient sign of each lane
  } div_side_t;

  // Hit record as it leaves the last stage.
  typedef struct packed {
    logic        hit;
    logic        in_box;
    logic [31:0] dist_val;
  } result_t;

endpackage

// ===== design/ray_box_slab_intersection.sv =====
`timescale 1ns / 1ps
// Throughput: one ray per cycle while the skid entry is empty;
// six 56-step restoring dividers, one quotient bit per stage.
// A result stalled at the output is backed by one skid entry before the input stalls.
// Reset clears all configuration registers to zero and empties the pipeline.
// No clearing pass is needed after reset.
`include "ray_box_slab_intersection_assert.svh"
module ray_box_slab_intersection (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               ray_valid,
  output logic               ray_stall,
  input  logic signed [15:0] origin_x,
  input  logic signed [15:0] origin_y,
  input  logic signed [15:0] origin_z,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               hit,
  output logic               started_inside,
  output logic signed [31:0] distance
);

  localparam int PROD_W = rbsi_pkg::PROD_W;
  localparam int SUM_W = rbsi_pkg::SUM_W;
  localparam int NUM_W = rbsi_pkg::NUM_W;
  localparam int MAG_W = rbsi_pkg::MAG_W;
  localparam int DVD_W = rbsi_pkg::DVD_W;
  localparam int REM_W = rbsi_pkg::REM_W;
  localparam int T_W   = rbsi_pkg::T_W;
  localparam logic signed [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};
  localparam logic signed [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
  localparam logic signed [T_W-1:0] DIST_MAX = {{(T_W-31){1'b0}}, {31{1'b1}}};

  // Configuration registers.
  logic [63:0] rows [3];
  logic [47:0] box_lo;
  logic [47:0] box_hi;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0] <= '0;
      rows[1] <= '0;
      rows[2] <= '0;
      box_lo  <= '0;
      box_hi  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (rbsi_pkg::cfg_index_t'(cfg_index))
        rbsi_pkg::CFG_ROW_X:    rows[0] <= cfg_data;
        rbsi_pkg::CFG_ROW_Y:    rows[1] <= cfg_data;
        rbsi_pkg::CFG_ROW_Z:    rows[2] <= cfg_data;
        rbsi_pkg::CFG_BOX_LOW:  box_lo  <= cfg_data[47:0];
        rbsi_pkg::CFG_BOX_HIGH: box_hi  <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline advances together unless the skid entry is full.
  logic skid_valid;
  logic en;
  assign en        = !skid_valid;
  assign ray_stall = skid_valid;

  logic signed [15:0] o_in [3];
  logic signed [15:0] d_in [3];
  assign o_in[0] = origin_x;
  assign o_in[1] = origin_y;
  assign o_in[2] = origin_z;
  assign d_in[0] = dir_x;
  assign d_in[1] = dir_y;
  assign d_in[2] = dir_z;

  // Stage 1: matrix products.
  logic                      s1_valid;
  logic signed [PROD_W-1:0]  prod_o [3][3];
  logic signed [PROD_W-1:0]  prod_d [3][3];
  logic signed [15:0]        s1_tr  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= ray_valid;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_prod
    always_ff @(posedge clk) begin
      if (en) begin
        s1_tr[i] <= signed'(rows[i][63:48]);
      end
    end
    for (genvar j = 0; j < 3; j++) begin : g_col
      logic signed [15:0] m;
      assign m = signed'(rows[i][16*j +: 16]);
      always_ff @(posedge clk) begin
        if (en) begin
          prod_o[i][j] <= m * o_in[j];
          prod_d[i][j] <= m * d_in[j];
        end
      end
    end
  end

  // Stage 2: transformed origin and direction.
  logic                    s2_valid;
  logic signed [SUM_W-1:0] po [3];
  logic signed [SUM_W-1:0] pd [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_sum
    logic signed [SUM_W-1:0] tr_w;
    assign tr_w = $signed({{(SUM_W-24){s1_tr[i][15]}}, s1_tr[i], 8'b0});
    always_ff @(posedge clk) begin
      if (en) begin
        po[i] <= SUM_W'(prod_o[i][0]) + SUM_W'(prod_o[i][1]) + SUM_W'(prod_o[i][2]) + tr_w;
        pd[i] <= SUM_W'(prod_d[i][0]) + SUM_W'(prod_d[i][1]) + SUM_W'(prod_d[i][2]);
      end
    end
  end

  // Divider pipeline storage; index 0 is the load stage.
  logic                  dv   [DVD_W+1];
  rbsi_pkg::div_side_t   side [DVD_W+1];
  logic [REM_W-1:0]      dsr  [DVD_W+1][3];
  logic [REM_W-1:0]      rem  [DVD_W+1][6];
  logic [DVD_W-1:0]      dq   [DVD_W+1][6];

  // Stage 3: slab numerators, signs and parallel checks.
  logic [2:0] par_c;
  logic [2:0] pmiss_c;
  logic [5:0] neg_c;

  for (genvar i = 0; i < 3; i++) begin : g_num
    logic signed [15:0]      lo;
    logic signed [15:0]      hi;
    logic signed [NUM_W-1:0] lo_w;
    logic signed [NUM_W-1:0] hi_w;
    logic signed [NUM_W-1:0] po_w;
    logic signed [NUM_W-1:0] num_lo;
    logic signed [NUM_W-1:0] num_hi;
    logic signed [NUM_W-1:0] abs_lo;
    logic signed [NUM_W-1:0] abs_hi;
    logic signed [SUM_W-1:0] abs_pd;
    logic                    pd_neg;

    assign lo     = signed'(box_lo[16*i +: 16]);
    assign hi     = signed'(box_hi[16*i +: 16]);
    assign lo_w   = $signed({{(NUM_W-28){lo[15]}}, lo, 12'b0});
    assign hi_w   = $signed({{(NUM_W-28){hi[15]}}, hi, 12'b0});
    assign po_w   = $signed({po[i][SUM_W-1], po[i]});
    assign num_lo = lo_w - po_w;
    assign num_hi = hi_w - po_w;
    assign abs_lo = num_lo[NUM_W-1] ? -num_lo : num_lo;
    assign abs_hi = num_hi[NUM_W-1] ? -num_hi : num_hi;
    assign pd_neg = pd[i][SUM_W-1];
    assign abs_pd = pd_neg ? -pd[i] : pd[i];

    assign par_c[i]     = (pd[i] <= rbsi_pkg::PAR_EPS) && (pd[i] >= -rbsi_pkg::PAR_EPS);
    assign pmiss_c[i]   = par_c[i] && ((po_w < lo_w) || (po_w > hi_w));
    assign neg_c[2*i]   = num_lo[NUM_W-1] ^ pd_neg;
    assign neg_c[2*i+1] = num_hi[NUM_W-1] ^ pd_neg;

    always_ff @(posedge clk) begin
      if (en) begin
        dsr[0][i]     <= abs_pd[REM_W-1:0];
        rem[0][2*i]   <= '0;
        rem[0][2*i+1] <= '0;
        dq[0][2*i]    <= {abs_lo[MAG_W-1:0], {rbsi_pkg::FRAC_SHIFT{1'b0}}};
        dq[0][2*i+1]  <= {abs_hi[MAG_W-1:0], {rbsi_pkg::FRAC_SHIFT{1'b0}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= '{par: par_c, par_miss: |pmiss_c, neg: neg_c};
    end
  end

  // Restoring division, one quotient bit per stage in each of six lanes.
  for (genvar k = 1; k <= DVD_W; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else if (en) begin
        dv[k] <= dv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[k] <= side[k-1];
        dsr[k]  <= dsr[k-1];
      end
    end

    for (genvar l = 0; l < 6; l++) begin : g_lane
      logic [REM_W:0] shifted;
      logic [REM_W:0] diff;
      logic           qb;
      assign shifted = {rem[k-1][l], dq[k-1][l][DVD_W-1]};
      assign diff    = shifted - {1'b0, dsr[k-1][l/2]};
      assign qb      = !diff[REM_W];
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k][l] <= qb ? diff[REM_W-1:0] : shifted[REM_W-1:0];
          dq[k][l]  <= {dq[k-1][l][DVD_W-2:0], qb};
        end
      end
    end
  end

  // Post stage 1: signed slab distances, ordered per axis.
  logic                  p1_valid;
  logic [2:0]            p1_par;
  logic                  p1_miss;
  logic signed [T_W-1:0] p1_a [3];
  logic signed [T_W-1:0] p1_b [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= dv[DVD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_par  <= side[DVD_W].par;
      p1_miss <= side[DVD_W].par_miss;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_order
    logic signed [T_W-1:0] q1;
    logic signed [T_W-1:0] q2;
    logic signed [T_W-1:0] t1;
    logic signed [T_W-1:0] t2;
    assign q1 = $signed({{(T_W-DVD_W){1'b0}}, dq[DVD_W][2*i]});
    assign q2 = $signed({{(T_W-DVD_W){1'b0}}, dq[DVD_W][2*i+1]});
    assign t1 = side[DVD_W].neg[2*i]   ? -q1 : q1;
    assign t2 = side[DVD_W].neg[2*i+1] ? -q2 : q2;
    always_ff @(posedge clk) begin
      if (en) begin
        p1_a[i] <= (t1 < t2) ? t1 : t2;
        p1_b[i] <= (t1 < t2) ? t2 : t1;
      end
    end
  end

  // Post stage 2: entry and exit distances over the bounded slabs.
  logic                  p2_valid;
  logic                  p2_miss;
  logic                  p2_bounded;
  logic signed [T_W-1:0] p2_near;
  logic signed [T_W-1:0] p2_far;
  logic signed [T_W-1:0] near_c;
  logic signed [T_W-1:0] far_c;

  always_comb begin
    near_c = T_MIN;
    far_c  = T_MAX;
    for (int i = 0; i < 3; i++) begin
      if (!p1_par[i] && (p1_a[i] > near_c)) near_c = p1_a[i];
      if (!p1_par[i] && (p1_b[i] < far_c))  far_c  = p1_b[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_miss    <= p1_miss;
      p2_bounded <= !(&p1_par);
      p2_near    <= near_c;
      p2_far     <= far_c;
    end
  end

  // Hit decision and saturation feeding the output register.
  rbsi_pkg::result_t     res_c;
  logic signed [T_W-1:0] t_sel;
  logic                  hit_c;
  logic                  inside_c;

  assign hit_c    = !p2_miss && p2_bounded && (p2_far >= p2_near) && !p2_far[T_W-1];
  assign inside_c = p2_near[T_W-1];
  assign t_sel    = inside_c ? p2_far : p2_near;

  always_comb begin
    res_c = '0;
    if (hit_c) begin
      res_c.hit      = 1'b1;
      res_c.in_box   = inside_c;
      res_c.dist_val = (t_sel > DIST_MAX) ? DIST_MAX[31:0] : t_sel[31:0];
    end
  end

  // Output register with one skid entry behind it.
  logic              produce;
  rbsi_pkg::result_t skid;

  assign produce = p2_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= skid_valid || produce;
      skid_valid   <= 1'b0;
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        hit            <= skid.hit;
        started_inside <= skid.in_box;
        distance       <= signed'(skid.dist_val);
      end else begin
        hit            <= res_c.hit;
        started_inside <= res_c.in_box;
        distance       <= signed'(res_c.dist_val);
      end
    end else if (produce) begin
      skid <= res_c;
    end
  end

  // The skid entry only fills while a result is held at the output.
  `RBSI_ASSERT_NOW(a_skid_behind_output, skid_valid, result_valid, "skid full with empty output")
  // A free output drains the skid entry in the next cycle.
  `RBSI_ASSERT_NEXT(a_skid_drains, skid_valid && !result_stall, !skid_valid, "skid did not drain")
  // A miss carries no distance and no inside flag.
  `RBSI_ASSERT_NOW(a_miss_clean, result_valid && !hit, (distance == 0) && !started_inside,
    "miss with nonzero payload")
  // A reported distance is never negative.
  `RBSI_ASSERT_NOW(a_dist_nonneg, result_valid && hit, !distance[31], "negative hit distance")

endmodule
